// ----- hdl/nha_pkg.sv -----
`timescale 1ns / 1ps

package nha_pkg;

    localparam int NET_W   = 12;
    localparam int COORD_W = 32;
    localparam int WGT_W   = 16;
    localparam int WL_W    = 33;
    localparam int CHG_W   = 34;
    localparam int TOT_W   = 63;
    localparam int PROD_W  = WL_W + WGT_W;

    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 144;

    // input tdata layout
    localparam int NET_LSB = 0;
    localparam int X_LSB   = NET_LSB + NET_W;
    localparam int Y_LSB   = X_LSB + COORD_W;
    localparam int ACT_LSB = Y_LSB + COORD_W;
    localparam int WGT_LSB = ACT_LSB + 1;
    localparam int S_USED_W = WGT_LSB + WGT_W;

    // input tuser layout
    localparam int USER_FIRST = 0;
    localparam int USER_START = 1;

    // result tdata layout
    localparam int R_NET_LSB = 0;
    localparam int R_WL_LSB  = R_NET_LSB + NET_W;
    localparam int R_CHG_LSB = R_WL_LSB + WL_W;
    localparam int R_TOT_LSB = R_CHG_LSB + CHG_W;
    localparam int M_USED_W  = R_TOT_LSB + TOT_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPDATE_CACHE = 1'b0,
        CFG_USE_WEIGHTS  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             start;
        logic             active;
        logic             in_range;
        logic [NET_W-1:0] net;
        logic [WGT_W-1:0] weight;
    } pin_ctl_t;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    start;
        logic [NET_W-1:0]        net;
        logic [WL_W-1:0]         wl;
        logic signed [CHG_W-1:0] change;
        logic [WGT_W-1:0]        weight;
    } net_res_t;

endpackage

// ----- hdl/net_hpwl_accumulator.sv -----
`timescale 1ns / 1ps

// Net half-perimeter wirelength accumulator. Pins stream in one per cycle, grouped by
// net with first/last marks; the last pin of a net yields one result item carrying the
// net's bounding-box half-perimeter, its change against a per-net cache and a saturating
// running total. The block takes one pin every cycle while the result side keeps up; the
// whole pipeline, input included, stalls while a result item waits on m_tready. A result
// item reaches the output through the pin stage with cache read, then wirelength and
// change, weight multiply and total add, each registered in turn. The per-net cache is a
// single memory with a registered read and a same-edge write forward; after reset a
// clearing pass zeroes it at one entry per cycle, so s_tready stays low until every entry
// is cleared.

module net_hpwl_accumulator #(
    parameter int NET_COUNT            = 4096,
    parameter int WEIGHT_FRACTION_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // net_index, pin_x, pin_y, net_active, net_weight, zero pad
    input  logic [nha_pkg::S_DATA_W-1:0]      s_tdata,
    // first_pin, start_pass
    input  logic [nha_pkg::S_USER_W-1:0]      s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_net, net_wirelength, wirelength_change, running_total, zero pad
    output logic [nha_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [nha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nha_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int ADDR_W = $clog2(NET_COUNT);
    localparam int IDX_W  = ((ADDR_W > nha_pkg::NET_W) ? ADDR_W : nha_pkg::NET_W) + 1;

    logic                             update_cache_reg;
    logic                             use_weights_reg;
    logic                             pipe_en;
    logic                             cache_busy;
    logic                             accept;
    logic [nha_pkg::NET_W-1:0]        s_net;
    logic [IDX_W-1:0]                 s_net_wide;
    logic                             s_in_range;
    logic [nha_pkg::WL_W-1:0]         box_wl;
    logic [nha_pkg::WL_W-1:0]         wl1;
    logic [nha_pkg::WL_W-1:0]         cache_rd;
    logic [nha_pkg::WL_W-1:0]         cached1;
    logic [IDX_W-1:0]                 p1_net_wide;
    logic                             cache_wr_en;
    nha_pkg::pin_ctl_t                p1_reg, p1_next;
    nha_pkg::net_res_t                res1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            update_cache_reg <= 1'b0;
            use_weights_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (nha_pkg::cfg_reg_t'(cfg_index))
                nha_pkg::CFG_UPDATE_CACHE: update_cache_reg <= cfg_wdata[0];
                nha_pkg::CFG_USE_WEIGHTS:  use_weights_reg  <= cfg_wdata[0];
            endcase
        end
    end

    assign s_tready   = pipe_en && !cache_busy;
    assign accept     = s_tvalid && s_tready;
    assign s_net      = s_tdata[nha_pkg::NET_LSB +: nha_pkg::NET_W];
    assign s_net_wide = IDX_W'(s_net);
    assign s_in_range = s_net_wide < IDX_W'(NET_COUNT);

    always_comb begin
        p1_next.valid    = accept;
        p1_next.last     = s_tlast;
        p1_next.start    = s_tuser[nha_pkg::USER_START];
        p1_next.active   = s_tdata[nha_pkg::ACT_LSB];
        p1_next.in_range = s_in_range;
        p1_next.net      = s_net;
        p1_next.weight   = s_tdata[nha_pkg::WGT_LSB +: nha_pkg::WGT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            p1_reg.valid <= p1_next.valid;
        end
        if (pipe_en) begin
            p1_reg.last     <= p1_next.last;
            p1_reg.start    <= p1_next.start;
            p1_reg.active   <= p1_next.active;
            p1_reg.in_range <= p1_next.in_range;
            p1_reg.net      <= p1_next.net;
            p1_reg.weight   <= p1_next.weight;
        end
    end

    nha_box u_box (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd_en  (accept),
        .first   (s_tuser[nha_pkg::USER_FIRST]),
        .pin_x   (s_tdata[nha_pkg::X_LSB +: nha_pkg::COORD_W]),
        .pin_y   (s_tdata[nha_pkg::Y_LSB +: nha_pkg::COORD_W]),
        .box_wl  (box_wl)
    );

    assign wl1         = p1_reg.active ? box_wl : '0;
    assign p1_net_wide = IDX_W'(p1_reg.net);
    assign cache_wr_en = p1_reg.valid && p1_reg.last && p1_reg.in_range && update_cache_reg;

    nha_cache #(
        .NET_COUNT (NET_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (pipe_en),
        .rd_en   (accept && s_tlast && s_in_range),
        .rd_addr (s_net_wide[ADDR_W-1:0]),
        .wr_en   (cache_wr_en),
        .wr_addr (p1_net_wide[ADDR_W-1:0]),
        .wr_data (wl1),
        .rd_data (cache_rd),
        .busy    (cache_busy)
    );

    assign cached1 = p1_reg.in_range ? cache_rd : '0;

    always_comb begin
        res1.valid  = p1_reg.valid;
        res1.last   = p1_reg.last;
        res1.start  = p1_reg.start;
        res1.net    = p1_reg.net;
        res1.wl     = wl1;
        res1.change = $signed({1'b0, wl1}) - $signed({1'b0, cached1});
        res1.weight = p1_reg.weight;
    end

    nha_accum #(
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_in      (res1),
        .use_weights (use_weights_reg),
        .pipe_en     (pipe_en),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- hdl/nha_box.sv -----
`timescale 1ns / 1ps

module nha_box (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 upd_en,
    input  logic                                 first,
    input  logic signed [nha_pkg::COORD_W-1:0]   pin_x,
    input  logic signed [nha_pkg::COORD_W-1:0]   pin_y,
    output logic [nha_pkg::WL_W-1:0]             box_wl
);

    logic signed [nha_pkg::COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [nha_pkg::COORD_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic [nha_pkg::COORD_W-1:0] dx, dy;

    always_comb begin
        if (first) begin
            min_x_next = pin_x;
            max_x_next = pin_x;
            min_y_next = pin_y;
            max_y_next = pin_y;
        end else begin
            min_x_next = (pin_x < min_x_reg) ? pin_x : min_x_reg;
            max_x_next = (pin_x > max_x_reg) ? pin_x : max_x_reg;
            min_y_next = (pin_y < min_y_reg) ? pin_y : min_y_reg;
            max_y_next = (pin_y > max_y_reg) ? pin_y : max_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
        end else if (upd_en) begin
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
        end
    end

    // max never below min, so the wrapped difference is the unsigned extent
    assign dx = nha_pkg::COORD_W'(max_x_reg - min_x_reg);
    assign dy = nha_pkg::COORD_W'(max_y_reg - min_y_reg);
    assign box_wl = {1'b0, dx} + {1'b0, dy};

endmodule

// ----- hdl/nha_cache.sv -----
`timescale 1ns / 1ps

module nha_cache #(
    parameter int NET_COUNT = 4096,
    parameter int ADDR_W    = $clog2(NET_COUNT)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [nha_pkg::WL_W-1:0]     wr_data,
    output logic [nha_pkg::WL_W-1:0]     rd_data,
    output logic                         busy
);

    logic [nha_pkg::WL_W-1:0] mem_array [NET_COUNT];
    logic                     clr_active_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic [nha_pkg::WL_W-1:0] rd_data_reg;
    logic                     fwd_hit_reg;
    logic [nha_pkg::WL_W-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(NET_COUNT - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (adv) begin
                fwd_hit_reg <= wr_en && rd_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem_array[clr_addr_reg] <= '0;
        end else if (adv && wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (adv && rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
        if (adv) begin
            fwd_data_reg <= wr_data;
        end
    end

    // write and read of the same net at one edge: take the value being written
    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

// ----- hdl/nha_accum.sv -----
`timescale 1ns / 1ps

module nha_accum #(
    parameter int WEIGHT_FRACTION_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  nha_pkg::net_res_t               res_in,
    input  logic                            use_weights,
    output logic                            pipe_en,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nha_pkg::M_DATA_W-1:0]    m_tdata
);

    nha_pkg::net_res_t          s2_reg;
    logic                       s3_valid_reg;
    logic                       s3_last_reg;
    logic                       s3_start_reg;
    logic [nha_pkg::NET_W-1:0]  s3_net_reg;
    logic [nha_pkg::WL_W-1:0]   s3_wl_reg;
    logic [nha_pkg::CHG_W-1:0]  s3_chg_reg;
    logic [nha_pkg::PROD_W-1:0] s3_contrib_reg;
    logic [nha_pkg::TOT_W-1:0]  total_reg, total_next, total_base;
    logic [nha_pkg::TOT_W:0]    total_sum;
    logic [nha_pkg::PROD_W-1:0] product, contrib_next;
    logic                       m_valid_reg;
    logic [nha_pkg::M_DATA_W-1:0] m_data_reg;

    assign pipe_en = !m_valid_reg || m_tready;

    assign product      = nha_pkg::PROD_W'(s2_reg.wl) * nha_pkg::PROD_W'(s2_reg.weight);
    assign contrib_next = use_weights ? (product >> WEIGHT_FRACTION_BITS)
                                      : nha_pkg::PROD_W'(s2_reg.wl);

    always_comb begin
        total_base = s3_start_reg ? '0 : total_reg;
        total_sum  = {1'b0, total_base} + (nha_pkg::TOT_W + 1)'(s3_contrib_reg);
        if (!s3_last_reg) begin
            total_next = total_base;
        end else if (total_sum[nha_pkg::TOT_W]) begin
            total_next = '1;
        end else begin
            total_next = total_sum[nha_pkg::TOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            total_reg    <= '0;
        end else if (pipe_en) begin
            s2_reg.valid <= res_in.valid;
            s3_valid_reg <= s2_reg.valid;
            m_valid_reg  <= s3_valid_reg && s3_last_reg;
            if (s3_valid_reg) begin
                total_reg <= total_next;
            end
        end
        if (pipe_en) begin
            s2_reg.last    <= res_in.last;
            s2_reg.start   <= res_in.start;
            s2_reg.net     <= res_in.net;
            s2_reg.wl      <= res_in.wl;
            s2_reg.change  <= res_in.change;
            s2_reg.weight  <= res_in.weight;
            s3_last_reg    <= s2_reg.last;
            s3_start_reg   <= s2_reg.start;
            s3_net_reg     <= s2_reg.net;
            s3_wl_reg      <= s2_reg.wl;
            s3_chg_reg     <= s2_reg.change;
            s3_contrib_reg <= contrib_next;
            m_data_reg     <= {(nha_pkg::M_DATA_W - nha_pkg::M_USED_W)'(0), total_next,
                               s3_chg_reg, s3_wl_reg, s3_net_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- hdl/nha_checker.sv -----
`timescale 1ns / 1ps

module nha_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [nha_pkg::M_DATA_W-1:0]     m_tdata
);

    logic                              last_accept;
    logic signed [nha_pkg::CHG_W-1:0]  res_change;
    logic [nha_pkg::WL_W-1:0]          res_wl;

    assign last_accept = s_tvalid && s_tready && s_tlast;
    assign res_change  = m_tdata[nha_pkg::R_CHG_LSB +: nha_pkg::CHG_W];
    assign res_wl      = m_tdata[nha_pkg::R_WL_LSB +: nha_pkg::WL_W];

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // cache clearing pass keeps the input closed after reset
    a_clear_pass: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // last pin gives a result once m_tready has let it through every pipeline register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        last_accept ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result item missing after last pin");

    // cached value is never negative, so change cannot exceed the new wirelength
    a_change_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_change <= $signed({1'b0, res_wl}))
        else $error("wirelength change above wirelength");

endmodule

bind net_hpwl_accumulator nha_checker u_nha_checker (.*);

// ----- test/tb_net_hpwl_accumulator.sv -----
`timescale 1ns / 1ps

module tb_net_hpwl_accumulator;

    localparam int NETS             = 4096;
    localparam int WFB              = 8;
    localparam int IDLE_PCT         = 26;
    localparam int STALL_LIMIT      = 20000;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PER_PHASE = 195;
    localparam int SETTLE_CYCLES    = 12;
    localparam int COORD_MIN        = 32'h8000_0000;
    localparam int COORD_MAX        = 32'h7fff_ffff;
    localparam logic [nha_pkg::TOT_W-1:0] TOTAL_MAX = '1;

    typedef struct {
        logic [nha_pkg::NET_W-1:0] net;
        int                        x;
        int                        y;
        bit                        first;
        bit                        last;
        bit                        active;
        logic [nha_pkg::WGT_W-1:0] weight;
        bit                        start;
    } pin_t;

    typedef struct {
        logic [nha_pkg::NET_W-1:0] net;
        logic [nha_pkg::WL_W-1:0]  wl;
        logic [nha_pkg::CHG_W-1:0] change;
        logic [nha_pkg::TOT_W-1:0] total;
    } net_result_t;

    class hpwl_scoreboard;
        int                        min_x, max_x, min_y, max_y;
        logic [nha_pkg::TOT_W-1:0] total;
        logic [nha_pkg::WL_W-1:0]  cache [NETS];
        bit                        update_cache;
        bit                        use_weights;
        net_result_t               expected_q[$];
        int                        errors;

        function new();
            min_x = 0;
            max_x = 0;
            min_y = 0;
            max_y = 0;
            total = '0;
            foreach (cache[i]) cache[i] = '0;
            update_cache = 0;
            use_weights = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted pin item
        function void note_pin(pin_t p);
            net_result_t r;
            longint      span;
            logic [63:0] contrib;
            logic [63:0] room;
            if (p.start) total = '0;
            if (p.first) begin
                min_x = p.x;
                max_x = p.x;
                min_y = p.y;
                max_y = p.y;
            end else begin
                if (p.x < min_x) min_x = p.x;
                if (p.x > max_x) max_x = p.x;
                if (p.y < min_y) min_y = p.y;
                if (p.y > max_y) max_y = p.y;
            end
            if (!p.last) return;
            r.net = p.net;
            r.wl = '0;
            if (p.active) begin
                span = (longint'(max_x) - longint'(min_x)) + (longint'(max_y) - longint'(min_y));
                r.wl = span[nha_pkg::WL_W-1:0];
            end
            r.change = {1'b0, r.wl} - {1'b0, cache[p.net]};
            if (update_cache) cache[p.net] = r.wl;
            if (use_weights) contrib = ({31'b0, r.wl} * {48'b0, p.weight}) >> WFB;
            else contrib = {31'b0, r.wl};
            room = {1'b0, TOTAL_MAX} - {1'b0, total};
            if (contrib > room) total = TOTAL_MAX;
            else total = total + contrib[nha_pkg::TOT_W-1:0];
            r.total = total;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // one accepted result item
        function void check_result(logic [nha_pkg::M_DATA_W-1:0] d);
            net_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result item, expected none actual %h", $time, d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("result_net", 64'(e.net),
                          64'(d[nha_pkg::R_NET_LSB +: nha_pkg::NET_W]));
            compare_field("net_wirelength", 64'(e.wl),
                          64'(d[nha_pkg::R_WL_LSB +: nha_pkg::WL_W]));
            compare_field("wirelength_change", 64'(e.change),
                          64'(d[nha_pkg::R_CHG_LSB +: nha_pkg::CHG_W]));
            compare_field("running_total", 64'(e.total),
                          64'(d[nha_pkg::R_TOT_LSB +: nha_pkg::TOT_W]));
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [nha_pkg::S_DATA_W-1:0]   s_tdata;
    logic [nha_pkg::S_USER_W-1:0]   s_tuser;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [nha_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_wr_en;
    logic [nha_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nha_pkg::CFG_DATA_W-1:0] cfg_wdata;

    hpwl_scoreboard sb;
    pin_t           stim_q[$];
    bit             send_calm = 0;
    bit             recv_calm = 0;
    bit             hold_req = 0;
    int             hold_left = 0;
    int             stall_cnt = 0;

    net_hpwl_accumulator #(
        .NET_COUNT(NETS),
        .WEIGHT_FRACTION_BITS(WFB)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [nha_pkg::S_DATA_W-1:0] pack_pin(pin_t p);
        logic [nha_pkg::S_DATA_W-1:0] bus;
        bus = '0;
        bus[nha_pkg::NET_LSB +: nha_pkg::NET_W] = p.net;
        bus[nha_pkg::X_LSB +: nha_pkg::COORD_W] = p.x;
        bus[nha_pkg::Y_LSB +: nha_pkg::COORD_W] = p.y;
        bus[nha_pkg::ACT_LSB]                   = p.active;
        bus[nha_pkg::WGT_LSB +: nha_pkg::WGT_W] = p.weight;
        return bus;
    endfunction

    function automatic void push_pin(logic [nha_pkg::NET_W-1:0] net, int x, int y, bit first,
                                     bit last, bit active, logic [nha_pkg::WGT_W-1:0] weight,
                                     bit start);
        pin_t p;
        p.net = net;
        p.x = x;
        p.y = y;
        p.first = first;
        p.last = last;
        p.active = active;
        p.weight = weight;
        p.start = start;
        stim_q.insert(stim_q.size(), p);
    endfunction

    function automatic int rand_coord(int base);
        case ($urandom_range(9))
            0, 1, 2: return int'($urandom);
            3: begin
                case ($urandom_range(3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return base + int'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    function automatic logic [nha_pkg::WGT_W-1:0] rand_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return nha_pkg::WGT_W'(16'h0100);
            default: return nha_pkg::WGT_W'($urandom);
        endcase
    endfunction

    function automatic logic [nha_pkg::NET_W-1:0] rand_net();
        case ($urandom_range(9))
            0: return ($urandom_range(1) != 0) ? '1 : '0;
            1, 2: return nha_pkg::NET_W'($urandom);
            default: return nha_pkg::NET_W'($urandom_range(15));
        endcase
    endfunction

    // mostly well-formed nets, some broken mark sequences and stray pins
    function automatic void gen_nets(int count);
        int                        added;
        int                        kind;
        int                        n;
        int                        base;
        logic [nha_pkg::NET_W-1:0] net;
        logic [nha_pkg::WGT_W-1:0] weight;
        bit                        active;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(99);
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            net = rand_net();
            weight = rand_weight();
            active = ($urandom_range(99) < 85);
            base = ($urandom_range(1) != 0) ? int'($urandom) : int'($urandom_range(4000)) - 2000;
            if (kind < 88) begin
                for (int i = 0; i < n; i++) begin
                    push_pin(net, rand_coord(base), rand_coord(base), i == 0, i == n - 1,
                             active, weight, $urandom_range(24) == 0);
                end
            end else if (kind < 95) begin
                for (int i = 0; i < n; i++) begin
                    push_pin(net, rand_coord(base), rand_coord(base), $urandom_range(2) == 0,
                             $urandom_range(2) == 0, active, weight, $urandom_range(9) == 0);
                end
            end else begin
                n = 1;
                push_pin(nha_pkg::NET_W'($urandom), int'($urandom), int'($urandom),
                         1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         nha_pkg::WGT_W'($urandom), 1'($urandom_range(1)));
            end
            added += n;
        end
    endfunction

    task automatic set_mode(bit update_cache, bit use_weights);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= nha_pkg::CFG_UPDATE_CACHE;
        cfg_wdata <= update_cache;
        @(negedge aclk);
        cfg_index <= nha_pkg::CFG_USE_WEIGHTS;
        cfg_wdata <= use_weights;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.update_cache = update_cache;
        sb.use_weights = use_weights;
    endtask

    task automatic send_pins();
        pin_t p;
        logic [nha_pkg::S_USER_W-1:0] user;
        while (stim_q.size() != 0) begin
            p = stim_q.pop_front();
            user = '0;
            user[nha_pkg::USER_FIRST] = p.first;
            user[nha_pkg::USER_START] = p.start;
            @(negedge aclk);
            while (!send_calm && $urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tdata <= pack_pin(p);
            s_tuser <= user;
            s_tlast <= p.last;
            s_tvalid <= 1'b1;
            do @(posedge aclk); while (!s_tready);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= recv_calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        pin_t p;
        bit   moved;
        moved = 0;
        if (aresetn && s_tvalid && s_tready) begin
            p.net = s_tdata[nha_pkg::NET_LSB +: nha_pkg::NET_W];
            p.x = s_tdata[nha_pkg::X_LSB +: nha_pkg::COORD_W];
            p.y = s_tdata[nha_pkg::Y_LSB +: nha_pkg::COORD_W];
            p.active = s_tdata[nha_pkg::ACT_LSB];
            p.weight = s_tdata[nha_pkg::WGT_LSB +: nha_pkg::WGT_W];
            p.first = s_tuser[nha_pkg::USER_FIRST];
            p.start = s_tuser[nha_pkg::USER_START];
            p.last = s_tlast;
            sb.note_pin(p);
            moved = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
            moved = 1;
        end
        stall_cnt = moved ? 0 : stall_cnt + 1;
    end

    initial begin
        while (stall_cnt < STALL_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = nha_pkg::CFG_UPDATE_CACHE;
        cfg_wdata = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // no first pin after reset widens the point (0,0)
        push_pin(12'd7, 5, -3, 0, 1, 1, 16'h0100, 0);
        push_pin(12'd0, COORD_MAX, COORD_MIN, 1, 1, 1, 16'hffff, 0);
        push_pin(12'hfff, COORD_MIN, COORD_MIN, 1, 0, 1, 16'h0000, 0);
        push_pin(12'hfff, COORD_MAX, COORD_MAX, 0, 1, 1, 16'hffff, 0);
        push_pin(12'hfff, 10, 10, 1, 1, 0, 16'hffff, 0);
        push_pin(12'd1, 100, -50, 1, 0, 1, 16'h0100, 0);
        push_pin(12'd1, -20, 70, 0, 0, 1, 16'h0100, 1);
        push_pin(12'd1, 40, 0, 0, 1, 1, 16'h0000, 0);
        push_pin(12'd2, 0, 0, 1, 0, 1, 16'h0080, 0);
        push_pin(12'd2, -1, -1, 0, 0, 1, 16'h0080, 0);
        push_pin(12'd2, COORD_MAX, 0, 0, 1, 1, 16'h0080, 1);
        gen_nets(RANDOM_PER_PHASE);
        send_pins();
        drain();

        set_mode(1, 0);
        push_pin(12'hfff, COORD_MIN, COORD_MAX, 1, 0, 1, 16'h0100, 1);
        push_pin(12'hfff, COORD_MAX, COORD_MIN, 0, 1, 1, 16'h0100, 0);
        push_pin(12'hfff, 3, 3, 1, 1, 0, 16'h0100, 0);
        gen_nets(RANDOM_PER_PHASE);
        send_pins();
        drain();

        // receiver holds off while pins keep coming
        set_mode(1, 1);
        push_pin(12'hfff, COORD_MIN, COORD_MIN, 1, 0, 1, 16'hffff, 0);
        push_pin(12'hfff, COORD_MAX, COORD_MAX, 0, 1, 1, 16'hffff, 0);
        push_pin(12'd3, 0, 0, 1, 0, 1, 16'h0001, 0);
        push_pin(12'd3, 255, 0, 0, 1, 1, 16'h0001, 0);
        push_pin(12'd4, -7, 9, 1, 0, 1, 16'h0000, 0);
        push_pin(12'd4, 7, -9, 0, 1, 1, 16'h0000, 0);
        gen_nets(RANDOM_PER_PHASE);
        send_calm = 1;
        hold_req = 1;
        send_pins();
        send_calm = 0;
        drain();

        set_mode(0, 1);
        gen_nets(RANDOM_PER_PHASE);
        send_pins();
        drain();

        // no idling on either side
        set_mode(1, 1);
        gen_nets(RANDOM_PER_PHASE);
        send_calm = 1;
        recv_calm = 1;
        send_pins();
        drain();
        send_calm = 0;
        recv_calm = 0;

        set_mode(0, 0);
        gen_nets(RANDOM_PER_PHASE);
        send_pins();
        drain();

        if (sb.pending() != 0)
            $display("%0t: %0d expected result items never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/nha_pkg.sv
hdl/nha_box.sv
hdl/nha_cache.sv
hdl/nha_accum.sv
hdl/net_hpwl_accumulator.sv
hdl/nha_checker.sv
test/tb_net_hpwl_accumulator.sv
